>>> rtl/scl_pkg.sv
// Shared constants, codes and types of the serial command line matcher.
`timescale 1ns / 1ps
`default_nettype none

package scl_pkg;

    localparam int LINE_SIZE  = 64;
    localparam int NAME_SLOTS = 16;
    localparam int NAME_LEN   = 16;

    localparam int LINE_AW  = $clog2(LINE_SIZE);
    localparam int NT_DEPTH = NAME_SLOTS * NAME_LEN;
    localparam int NT_AW    = $clog2(NT_DEPTH);
    localparam int POS_W    = $clog2(NAME_LEN + 1);
    localparam int SLOT_W   = $clog2(NAME_SLOTS + 1);

    localparam int MODE_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int CNT_W    = 5;
    localparam int SLOTIN_W = 4;
    localparam int NPOS_W   = 4;
    localparam int IDX_W    = 6;
    localparam int KIND_W   = 2;
    localparam int CMD_W    = 4;
    localparam int LEN_W    = 6;

    localparam logic [BYTE_W-1:0] CH_CTRL_MAX = 8'h1F;
    localparam logic [BYTE_W-1:0] CH_DEL      = 8'h7F;
    localparam logic [BYTE_W-1:0] CH_LF       = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_ETX      = 8'h03;
    localparam logic [BYTE_W-1:0] CH_ESC      = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DOLLAR   = 8'h24;
    localparam logic [BYTE_W-1:0] CH_NUL      = 8'h00;

    localparam logic [MODE_W-1:0] MODE_RX   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NAME = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DONE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ECHO   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PROMPT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CMD    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LINE   = 2'd3;

    localparam logic [1:0] PROMPT_LAST = 2'd3;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_ECHO   = 7'b0000010,
        ST_PROMPT = 7'b0000100,
        ST_MRD    = 7'b0001000,
        ST_MCHK   = 7'b0010000,
        ST_MRES   = 7'b0100000,
        ST_READ   = 7'b1000000
    } state_t;

    // prompt: LF CR '$' space
    function automatic logic [BYTE_W-1:0] prompt_char(input logic [1:0] p);
        logic [BYTE_W-1:0] c;
        case (p)
            2'd0:    c = CH_LF;
            2'd1:    c = CH_CR;
            2'd2:    c = CH_DOLLAR;
            default: c = CH_SPACE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/scl_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module scl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

>>> rtl/serial_command_line_matcher.sv
// Top level of the serial command line matcher: sequencer, line store and name table.
//
// Items enter on item_valid/item_ready; results leave on result_valid/result_ready
// through one output register, and last marks the final result of an item.
// mode 0 is a received byte, 1 writes a name table character, 2 ends a command,
// 3 reads back a line byte. command_count is written through cfg_we/cfg_data.
// item_ready is high only while the sequencer is idle; one item at a time.
// A table write or a byte that gives no result leaves the sequencer idle. A line end
// with content walks the name table through the one-port line and name RAMs, each
// character compared in a read state (ST_MRD) and then a check state (ST_MCHK);
// with no live names it goes straight to the result.
// A stalled receiver holds the output register and the sequencer waits on it;
// the final result may wait there while the next item is taken.
// Reset empties the line (fill count zero, so unfilled positions read as zero),
// clears busy and command_count; the name table holds garbage until written.
`timescale 1ns / 1ps
`default_nettype none

module serial_command_line_matcher
    import scl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CNT_W-1:0]    cfg_data,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic [MODE_W-1:0]   mode,
    input  logic [BYTE_W-1:0]   data,
    input  logic [SLOTIN_W-1:0] slot,
    input  logic [NPOS_W-1:0]   name_pos,
    input  logic [IDX_W-1:0]    line_index,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [KIND_W-1:0]   kind,
    output logic [BYTE_W-1:0]   tx_byte,
    output logic [CMD_W-1:0]    cmd_index,
    output logic                cmd_found,
    output logic [LEN_W-1:0]    line_length,
    output logic                last
);

    state_t               state_reg, state_next;
    logic [LINE_AW-1:0]   fill_reg, fill_next;
    logic                 busy_reg, busy_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [1:0]           pcnt_reg, pcnt_next;
    logic                 prompt_p_reg, prompt_p_next;
    logic                 match_p_reg, match_p_next;
    logic                 rv_reg, rv_next;

    logic [BYTE_W-1:0]    data_reg;
    logic [IDX_W-1:0]     li_reg;
    logic [POS_W-1:0]     k_reg, k_next;
    logic [SLOT_W-1:0]    i_reg, i_next;
    logic [NT_AW-1:0]     base_reg, base_next;
    logic                 found_reg, found_next;

    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [BYTE_W-1:0]    tx_reg, tx_next;
    logic [CMD_W-1:0]     idx_reg, idx_next;
    logic                 fnd_reg, fnd_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic                 last_reg, last_next;
    logic                 load;

    logic                 line_we;
    logic [LINE_AW-1:0]   line_addr;
    logic [BYTE_W-1:0]    line_rdata;
    logic                 name_we;
    logic [NT_AW-1:0]     name_addr;
    logic [BYTE_W-1:0]    name_rdata;

    logic                 accept;
    logic                 ofree;
    logic [SLOT_W-1:0]    cnt_eff;
    logic                 printable;
    logic                 is_eol;
    logic                 is_abort;
    logic                 line_end;
    logic                 k_at_end;
    logic                 last_slot;
    state_t               match_entry;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign ofree      = !rv_reg || result_ready;

    assign cnt_eff   = (32'(cnt_reg) > NAME_SLOTS) ? SLOT_W'(NAME_SLOTS) : SLOT_W'(cnt_reg);
    assign printable = (data > CH_CTRL_MAX) && (data < CH_DEL);
    assign is_eol    = (data == CH_LF) || (data == CH_CR);
    assign is_abort  = (data == CH_ETX) || (data == CH_ESC) ||
                       (32'(fill_reg) >= LINE_SIZE - 2);
    assign line_end  = (32'(k_reg) >= 32'(fill_reg)) || (line_rdata == CH_SPACE);
    assign k_at_end  = (32'(k_reg) == NAME_LEN);
    assign last_slot = (32'(i_reg) + 1 >= 32'(cnt_eff));
    assign match_entry = (cnt_eff != '0) ? ST_MRD : ST_MRES;

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        busy_next     = busy_reg;
        pcnt_next     = pcnt_reg;
        prompt_p_next = prompt_p_reg;
        match_p_next  = match_p_reg;
        k_next        = k_reg;
        i_next        = i_reg;
        base_next     = base_reg;
        found_next    = found_reg;
        load          = 1'b0;
        kind_next     = KIND_ECHO;
        tx_next       = '0;
        idx_next      = '0;
        fnd_next      = 1'b0;
        len_next      = '0;
        last_next     = 1'b0;
        line_we       = 1'b0;
        line_addr     = LINE_AW'(li_reg);
        name_we       = 1'b0;
        name_addr     = base_reg + NT_AW'(k_reg);

        case (state_reg)
            ST_IDLE:
            begin
                line_addr = LINE_AW'(line_index);
                name_addr = NT_AW'(32'(slot) * NAME_LEN + 32'(name_pos));
                if (accept)
                begin
                    pcnt_next  = '0;
                    k_next     = '0;
                    i_next     = '0;
                    base_next  = '0;
                    found_next = 1'b0;
                    case (mode)
                        MODE_RX:
                        begin
                            if (!busy_reg)
                            begin
                                prompt_p_next = is_eol ? (fill_reg == '0) : is_abort;
                                match_p_next  = is_eol && (fill_reg != '0);
                                if (!is_eol && !is_abort && printable &&
                                    !((fill_reg == '0) && (data == CH_SPACE)))
                                begin
                                    line_we   = 1'b1;
                                    line_addr = fill_reg;
                                    fill_next = fill_reg + 1'b1;
                                end
                                if (printable)
                                    state_next = ST_ECHO;
                                else if (is_eol ? (fill_reg == '0) : is_abort)
                                    state_next = ST_PROMPT;
                                else if (is_eol)
                                    state_next = match_entry;
                            end
                        end
                        MODE_NAME:
                        begin
                            name_we = (32'(slot) < NAME_SLOTS) && (32'(name_pos) < NAME_LEN);
                        end
                        MODE_DONE:
                        begin
                            busy_next     = 1'b0;
                            prompt_p_next = 1'b1;
                            match_p_next  = 1'b0;
                            state_next    = ST_PROMPT;
                        end
                        MODE_READ:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ECHO:
            begin
                if (ofree)
                begin
                    load      = 1'b1;
                    kind_next = KIND_ECHO;
                    tx_next   = data_reg;
                    last_next = !(prompt_p_reg || match_p_reg);
                    if (prompt_p_reg)
                        state_next = ST_PROMPT;
                    else if (match_p_reg)
                        state_next = match_entry;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_PROMPT:
            begin
                if (ofree)
                begin
                    load      = 1'b1;
                    kind_next = KIND_PROMPT;
                    tx_next   = prompt_char(pcnt_reg);
                    last_next = (pcnt_reg == PROMPT_LAST);
                    pcnt_next = pcnt_reg + 1'b1;
                    if (pcnt_reg == PROMPT_LAST)
                    begin
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MRD:
            begin
                line_addr  = LINE_AW'(k_reg);
                state_next = ST_MCHK;
            end
            ST_MCHK:
            begin
                if (line_end && (k_at_end || (name_rdata == CH_NUL)))
                begin
                    found_next = 1'b1;
                    state_next = ST_MRES;
                end
                else if (line_end || k_at_end || (name_rdata != line_rdata))
                begin
                    k_next     = '0;
                    i_next     = i_reg + 1'b1;
                    base_next  = base_reg + NT_AW'(NAME_LEN);
                    state_next = last_slot ? ST_MRES : ST_MRD;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_MRD;
                end
            end
            ST_MRES:
            begin
                if (ofree)
                begin
                    load       = 1'b1;
                    kind_next  = KIND_CMD;
                    idx_next   = found_reg ? CMD_W'(i_reg) : '0;
                    fnd_next   = found_reg;
                    len_next   = LEN_W'(fill_reg);
                    last_next  = 1'b1;
                    busy_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (ofree)
                begin
                    load       = 1'b1;
                    kind_next  = KIND_LINE;
                    tx_next    = (32'(li_reg) < 32'(fill_reg)) ? line_rdata : '0;
                    len_next   = LEN_W'(fill_reg);
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rv_next = load ? 1'b1 : (result_ready ? 1'b0 : rv_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            busy_reg     <= 1'b0;
            cnt_reg      <= '0;
            pcnt_reg     <= '0;
            prompt_p_reg <= 1'b0;
            match_p_reg  <= 1'b0;
            rv_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            busy_reg     <= busy_next;
            pcnt_reg     <= pcnt_next;
            prompt_p_reg <= prompt_p_next;
            match_p_reg  <= match_p_next;
            rv_reg       <= rv_next;
            if (cfg_we)
            begin
                cnt_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        i_reg     <= i_next;
        base_reg  <= base_next;
        found_reg <= found_next;
        if (accept)
        begin
            data_reg <= data;
            li_reg   <= line_index;
        end
        if (load)
        begin
            kind_reg <= kind_next;
            tx_reg   <= tx_next;
            idx_reg  <= idx_next;
            fnd_reg  <= fnd_next;
            len_reg  <= len_next;
            last_reg <= last_next;
        end
    end

    scl_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LINE_SIZE)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .addr  (line_addr),
        .wdata (data),
        .rdata (line_rdata)
    );

    scl_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (NT_DEPTH)
    ) u_name_ram (
        .clk   (clk),
        .we    (name_we),
        .addr  (name_addr),
        .wdata (data),
        .rdata (name_rdata)
    );

    assign result_valid = rv_reg;
    assign kind         = kind_reg;
    assign tx_byte      = tx_reg;
    assign cmd_index    = idx_reg;
    assign cmd_found    = fnd_reg;
    assign line_length  = len_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire
